// ----- src/pxt_pkg.sv -----
package pxt_pkg;

   // word widths
   localparam int PosXWidth   = 32;
   localparam int PosYWidth   = 12;
   localparam int PosZWidth   = 32;
   localparam int WordWidth   = 64;
   localparam int TopWidth    = 24;
   localparam int ThreshWidth = 25;
   localparam int ReqWidth    = 80;
   localparam int RspWidth    = 96;
   localparam int CsrIdxWidth = 2;

   // hash multipliers
   localparam logic [31:0] MulX   = 32'd3129871;
   localparam logic [27:0] MulZ   = 28'd116129781;
   localparam logic [31:0] MulSq  = 32'd42317861;
   localparam int          RotAmt = 17;
   localparam int          TopLsb = 40;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] RegDeriverLow  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegDeriverHigh = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegThreshold   = 2'd2;

   // pipeline depth: five hash stages, one mix stage, one output stage
   localparam int HashStages = 5;
   localparam int NumStages  = 7;

   // per-stage load strobes from the flow control
   typedef struct packed {
      logic [NumStages-1:0] load;
   } pxt_ctrl_type;

endpackage

// ----- src/pxt_hash.sv -----
module pxt_hash (
   input  logic                            clock,
   input  pxt_pkg::pxt_ctrl_type           ctrl,
   input  logic [pxt_pkg::PosXWidth-1:0]   pos_x,
   input  logic [pxt_pkg::PosYWidth-1:0]   pos_y,
   input  logic [pxt_pkg::PosZWidth-1:0]   pos_z,
   output logic [pxt_pkg::WordWidth-1:0]   hash
);
   import pxt_pkg::*;

   logic [31:0]        px;
   logic signed [58:0] zp;
   logic [63:0]        h_in, h_ff;
   logic [63:0]        aa_in, aa_ff;
   logic [31:0]        ab_in, ab_ff;
   logic [63:0]        h11_in, h11_ff, h11b_ff, h11c_ff;
   logic [63:0]        sq_in, sq_ff;
   logic [63:0]        ck_in, ck_ff;
   logic [31:0]        dk_in, dk_ff;
   logic [63:0]        sum;
   logic [63:0]        hash_in, hash_ff;

   // stage 0: coordinate products and xor
   always_comb begin
      px   = pos_x * MulX;
      zp   = $signed(pos_z) * $signed({1'b0, MulZ});
      h_in = {{32{px[31]}}, px} ^ {{5{zp[58]}}, zp}
           ^ {{(64-PosYWidth){pos_y[PosYWidth-1]}}, pos_y};
   end

   // stage 1: partial products of h squared, and h times 11
   always_comb begin
      aa_in  = {32'd0, h_ff[31:0]} * {32'd0, h_ff[31:0]};
      ab_in  = h_ff[31:0] * h_ff[63:32];
      h11_in = (h_ff << 3) + (h_ff << 1) + h_ff;
   end

   // stage 2: h squared modulo 2^64
   assign sq_in = aa_ff + {ab_ff[30:0], 33'd0};

   // stage 3: partial products of the square times the constant
   always_comb begin
      ck_in = {32'd0, sq_ff[31:0]} * {32'd0, MulSq};
      dk_in = sq_ff[63:32] * MulSq;
   end

   // stage 4: final sum and arithmetic shift right by 16
   always_comb begin
      sum     = ck_ff + {dk_ff, 32'd0} + h11c_ff;
      hash_in = {{16{sum[63]}}, sum[63:16]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         h_ff <= h_in;
      end
      if (ctrl.load[1]) begin
         aa_ff  <= aa_in;
         ab_ff  <= ab_in;
         h11_ff <= h11_in;
      end
      if (ctrl.load[2]) begin
         sq_ff   <= sq_in;
         h11b_ff <= h11_ff;
      end
      if (ctrl.load[3]) begin
         ck_ff   <= ck_in;
         dk_ff   <= dk_in;
         h11c_ff <= h11b_ff;
      end
      if (ctrl.load[4]) begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ----- src/positional_xoroshiro_threshold_core.sv -----
// Positional random threshold core. Each request word carries a block
// position (pos_x, pos_y, pos_z); the core forms the positional hash, xors it
// into the low word of the configured generator state, runs one xoroshiro128++
// step and returns the 64-bit draw, its top 24 bits and a flag set when those
// bits are below the threshold register. Words are independent, so a new
// word is taken every cycle unless the output stalls; a result passes five
// hash stages (64-bit square split into 32-bit products), a mix stage and
// an output register. A stalled output holds its word while empty stages
// still fill, so the core takes new words until all 7 stages hold data.
// Users must write configuration via csr_ with no word in flight; unchecked.
module positional_xoroshiro_threshold_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [pxt_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [pxt_pkg::WordWidth-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x [31:0], pos_y [43:32], pos_z [75:44], zero [79:76]
   input  logic [pxt_pkg::ReqWidth-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // random_word [63:0], random_top [87:64], is_solid [88], zero [95:89]
   output logic [pxt_pkg::RspWidth-1:0]      rsp_tdata
);
   import pxt_pkg::*;

   logic [WordWidth-1:0]   deriver_low_ff, deriver_high_ff;
   logic [ThreshWidth-1:0] threshold_ff;
   logic [NumStages-1:0]   valid_ff;
   logic [NumStages-1:0]   ready;
   pxt_ctrl_type           ctrl;
   logic [WordWidth-1:0]   hash;
   logic [WordWidth-1:0]   lo_in, lo_ff;
   logic [WordWidth-1:0]   sum_in, sum_ff;
   logic [WordWidth-1:0]   rot;
   logic [WordWidth-1:0]   word_in, word_ff;
   logic [TopWidth-1:0]    top_in;
   logic                   solid_in, solid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deriver_low_ff  <= '0;
         deriver_high_ff <= '0;
         threshold_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            RegDeriverLow:  deriver_low_ff  <= csr_wdata;
            RegDeriverHigh: deriver_high_ff <= csr_wdata;
            RegThreshold:   threshold_ff    <= csr_wdata[ThreshWidth-1:0];
            default: ;
         endcase
      end
   end

   // stage readiness: a stage loads when empty or when the next one moves
   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || rsp_tready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      ctrl.load = ready;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NumStages; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   // hash pipeline
   pxt_hash u_hash (
      .clock (clock),
      .ctrl  (ctrl),
      .pos_x (req_tdata[31:0]),
      .pos_y (req_tdata[43:32]),
      .pos_z (req_tdata[75:44]),
      .hash  (hash)
   );

   // mix stage: xor the hash into the low word and add the high word
   always_comb begin
      lo_in  = deriver_low_ff ^ hash;
      sum_in = lo_in + deriver_high_ff;
   end

   // output stage: rotate, add, threshold compare
   always_comb begin
      rot      = {sum_ff[WordWidth-1-RotAmt:0], sum_ff[WordWidth-1:WordWidth-RotAmt]};
      word_in  = rot + lo_ff;
      top_in   = word_in[WordWidth-1:TopLsb];
      solid_in = {1'b0, top_in} < threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (ready[HashStages]) begin
         lo_ff  <= lo_in;
         sum_ff <= sum_in;
      end
      if (ready[NumStages-1]) begin
         word_ff  <= word_in;
         solid_ff <= solid_in;
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NumStages-1];
   assign rsp_tdata  = {7'd0, solid_ff, word_ff[WordWidth-1:TopLsb], word_ff};

endmodule

// ----- src/pxt_checker.sv -----
module pxt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pxt_pkg::RspWidth-1:0]      rsp_tdata
);
   import pxt_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // top field mirrors the upper bits of the draw
   a_top_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:64] == rsp_tdata[63:40])
      else $error("random_top does not match random_word");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95:89] == 7'd0)
      else $error("result padding not zero");

   // the request side only blocks when the pipeline is full and stalled
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request blocked without output stall");

endmodule

bind positional_xoroshiro_threshold_core pxt_checker u_pxt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb_positional_xoroshiro_threshold_core.sv -----
`timescale 1ns / 100ps

module tb_positional_xoroshiro_threshold_core;
   import pxt_pkg::*;

   // hash constants, the 64-bit product ones at full word width for wrap-around math
   localparam logic [31:0] XMult     = 32'd3129871;
   localparam logic [63:0] ZMult     = 64'd116129781;
   localparam logic [63:0] SqMult    = 64'd42317861;
   localparam logic [63:0] LinMult   = 64'd11;
   localparam logic [CsrIdxWidth-1:0] RegUnused = 2'd3;
   localparam logic [24:0] ThreshFull = 25'h1000000;
   localparam int          Latency    = NumStages;
   localparam int          CycleLimit = 200000;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic [TopWidth-1:0]  top;
      logic                 solid;
   } draw_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wen = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [WordWidth-1:0]    csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqWidth-1:0]     req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspWidth-1:0]     rsp_tdata;

   // shadow copy of the configuration registers
   logic [WordWidth-1:0]    low_word = '0;
   logic [WordWidth-1:0]    high_word = '0;
   logic [ThreshWidth-1:0]  thresh_level = '0;

   draw_type pending_draws[$];
   int    mismatch_count = 0;
   int    cycle_count = 0;
   int    stall_left = 0;
   bit    steady_flow = 1'b0;

   positional_xoroshiro_threshold_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("positional_xoroshiro_threshold_core test failed");
         $finish;
      end
   end

   // positional hash, one generator step and the threshold compare
   function automatic draw_type predict_draw(logic [31:0] x, logic [11:0] y, logic [31:0] z);
      logic [31:0] px;
      logic [63:0] h;
      logic [63:0] lo;
      logic [63:0] sum;
      draw_type d;
      px = x * XMult;
      h = {{32{px[31]}}, px};
      h = h ^ ({{32{z[31]}}, z} * ZMult);
      h = h ^ {{52{y[11]}}, y};
      h = h * h * SqMult + h * LinMult;
      h = $signed(h) >>> 16;
      lo = low_word ^ h;
      sum = lo + high_word;
      d.word = {sum[46:0], sum[63:47]} + lo;
      d.top = d.word[63:40];
      d.solid = ({1'b0, d.top} < thresh_level);
      return d;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_draw(logic [RspWidth-1:0] data);
      draw_type want;
      if (pending_draws.size() == 0) begin
         report_mismatch("unexpected word", data[63:0], '0);
      end else begin
         want = pending_draws.pop_front();
         if (data[63:0] !== want.word)
            report_mismatch("random_word", data[63:0], want.word);
         if (data[87:64] !== want.top)
            report_mismatch("random_top", {40'd0, data[87:64]}, {40'd0, want.top});
         if (data[88] !== want.solid)
            report_mismatch("is_solid", {63'd0, data[88]}, {63'd0, want.solid});
      end
   endtask

   // result side: random back-pressure per word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_draw(rsp_tdata);
            stall_left = steady_flow ? 0 : $urandom_range(0, 6);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   // send one position word, called and returning at a rising edge
   task automatic send_position(logic [31:0] x, logic [11:0] y, logic [31:0] z);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, z, y, x};
      do @(posedge clock); while (!req_tready);
      pending_draws.push_back(predict_draw(x, y, z));
   endtask

   // wait until every word is back and the pipeline is empty
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (Latency + 3) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [63:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         RegDeriverLow:  low_word = value;
         RegDeriverHigh: high_word = value;
         RegThreshold:   thresh_level = value[ThreshWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] th);
      write_csr(RegDeriverLow, lo);
      write_csr(RegDeriverHigh, hi);
      write_csr(RegThreshold, th);
   endtask

   // registers at reset value: zero state, threshold zero never solid
   task automatic test_reset_state;
      send_position(32'd0, 12'd0, 32'd0);
      send_position(32'h8000_0000, 12'h800, 32'h8000_0000);
      send_position(32'h7fff_ffff, 12'h7ff, 32'h7fff_ffff);
      drain();
   endtask

   // coordinate extremes with mixed generator state
   task automatic test_coordinate_extremes;
      load_config(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd8388608);
      send_position(32'h8000_0000, 12'h000, 32'h0000_0000);
      send_position(32'h7fff_ffff, 12'h000, 32'h0000_0000);
      send_position(32'hffff_ffff, 12'h000, 32'h0000_0000);
      send_position(32'h0000_0000, 12'h800, 32'h0000_0000);
      send_position(32'h0000_0000, 12'h7ff, 32'h0000_0000);
      send_position(32'h0000_0000, 12'hfff, 32'h0000_0000);
      send_position(32'h0000_0000, 12'h000, 32'h8000_0000);
      send_position(32'h0000_0000, 12'h000, 32'h7fff_ffff);
      send_position(32'h0000_0000, 12'h000, 32'hffff_ffff);
      send_position(32'hffff_ffff, 12'hfff, 32'hffff_ffff);
      send_position(32'h0000_0001, 12'h001, 32'h0000_0001);
      send_position(32'h5555_5555, 12'haaa, 32'haaaa_aaaa);
      drain();
   endtask

   // threshold at full scale, one below, wider write masked, unused index
   task automatic test_threshold_edges;
      load_config(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'(ThreshFull));
      send_position(32'd12, 12'hfc4, 32'hffff_fff3);
      send_position(32'h1234_5678, 12'h3a5, 32'h9abc_def0);
      drain();
      write_csr(RegThreshold, 64'(ThreshFull) - 64'd1);
      send_position(32'd100, 12'd64, 32'd200);
      send_position(32'hffff_ff9c, 12'hfc0, 32'hffff_ff38);
      drain();
      // bits above the register width are dropped
      write_csr(RegThreshold, 64'hffff_ffff_ffff_ffff);
      send_position(32'd7, 12'd7, 32'd7);
      drain();
      // a write to the unused index changes nothing
      write_csr(RegUnused, 64'hdead_beef_dead_beef);
      send_position(32'd7, 12'd7, 32'd7);
      send_position(32'hcafe_f00d, 12'h5a5, 32'h0bad_f00d);
      drain();
   endtask

   // random positions under one configuration
   task automatic run_random_phase(int count, bit steady);
      logic [31:0] x;
      logic [11:0] y;
      logic [31:0] z;
      steady_flow = steady;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            // near-origin positions typical of a world search
            x = 32'($urandom_range(0, 4000)) - 32'd2000;
            z = 32'($urandom_range(0, 4000)) - 32'd2000;
         end else begin
            x = $urandom;
            z = $urandom;
         end
         y = 12'($urandom);
         send_position(x, y, z);
      end
      drain();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_positions;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] th;
      for (int phase = 0; phase < 6; phase++) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         case (phase)
            0: th = 64'd0;
            1: th = 64'(ThreshFull);
            2: begin
               lo = '0;
               hi = '1;
               th = 64'($urandom_range(0, 16777216));
            end
            3: begin
               lo = '1;
               hi = '0;
               th = 64'($urandom_range(0, 16777216));
            end
            default: th = 64'($urandom_range(0, 16777216));
         endcase
         load_config(lo, hi, th);
         run_random_phase(225, phase == 4);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_coordinate_extremes();
      test_threshold_edges();
      test_random_positions();
      drain();
      if (mismatch_count == 0) begin
         $display("positional_xoroshiro_threshold_core test passed");
      end else begin
         $display("positional_xoroshiro_threshold_core test failed");
      end
      $finish;
   end

endmodule
